// ===== rtl/wpc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types and constants for the web port packet classifier.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int OFFSET_W = 16;           // byte offset counter width (8..32)
  localparam int CMP_W    = OFFSET_W + 1; // offsets plus header reach, no wrap

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_MODE   = 3'd0,
    CFG_MPLS_ETYPE  = 3'd1,
    CFG_TAG_COLOR   = 3'd2,
    CFG_PORT_FIRST  = 3'd3,
    CFG_PORT_SECOND = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] LINK_ETH  = 2'd0;
  localparam logic [1:0] LINK_HDLC = 2'd1;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  localparam logic [OFFSET_W-1:0] MPLS_LABEL_BYTES = OFFSET_W'(4);
  localparam logic [OFFSET_W-1:0] OFFSET_MAX       = {OFFSET_W{1'b1}};

  typedef struct packed {
    logic [1:0]  link_mode;
    logic [15:0] mpls_ethertype;
    logic [7:0]  tag_color;
    logic [15:0] port_first;
    logic [15:0] port_second;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] color_in;
  } item_t;

  typedef struct packed {
    logic       is_web;
    logic [7:0] color_out;
  } result_t;

endpackage

// ===== rtl/wpc_in_reg.sv =====
// ----------------------------------------------------------------------------
// wpc_in_reg
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wpc_in_reg import wpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  assign s_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      held_item <= s_item;
    end
  end

endmodule

// ===== rtl/wpc_parser.sv =====
// ----------------------------------------------------------------------------
// wpc_parser
// Per-packet header walk: link type, optional VLAN tag and MPLS label,
// IPv4 IHL, TCP ports and data offset; forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module wpc_parser import wpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  typedef enum logic [1:0] {
    PH_LINK     = 2'd0,
    PH_IP       = 2'd1,
    PH_TCP_DONE = 2'd2,
    PH_VLAN     = 2'd3
  } phase_t;

  logic [OFFSET_W-1:0] byte_offset, byte_offset_next;
  phase_t              parse_phase, parse_phase_next;
  logic [15:0]         ether_kind, ether_kind_next;
  logic [OFFSET_W-1:0] ip_start, ip_start_next;
  logic [OFFSET_W-1:0] tcp_start, tcp_start_next;
  logic [OFFSET_W-1:0] payload_start, payload_start_next;
  logic [7:0]          ip_proto, ip_proto_next;
  logic [15:0]         src_port, src_port_next;
  logic [15:0]         dst_port, dst_port_next;
  logic [7:0]          held_color, held_color_next;
  logic                reject_flag, reject_flag_next;

  always_comb begin
    logic [OFFSET_W-1:0] o;
    logic [CMP_W-1:0]    oc;
    logic [CMP_W-1:0]    tc;
    logic [CMP_W-1:0]    count;
    logic [7:0]          b;
    logic                do_decide;
    logic [OFFSET_W-1:0] base;
    logic                color_ok;
    logic                port_ok;
    logic                match;

    b         = item.pkt_byte;
    do_decide = 1'b0;
    base      = '0;
    tc        = '0;

    byte_offset_next   = byte_offset;
    parse_phase_next   = parse_phase;
    ether_kind_next    = ether_kind;
    ip_start_next      = ip_start;
    tcp_start_next     = tcp_start;
    payload_start_next = payload_start;
    ip_proto_next      = ip_proto;
    src_port_next      = src_port;
    dst_port_next      = dst_port;
    held_color_next    = held_color;
    reject_flag_next   = reject_flag;

    // new packet: explicit first flag, or first byte after reset / last
    if (item.first_byte || byte_offset == '0) begin
      byte_offset_next   = '0;
      parse_phase_next   = PH_LINK;
      ether_kind_next    = '0;
      ip_start_next      = '0;
      tcp_start_next     = '0;
      payload_start_next = '0;
      ip_proto_next      = '0;
      src_port_next      = '0;
      dst_port_next      = '0;
      held_color_next    = item.color_in;
      reject_flag_next   = (cfg.link_mode != LINK_ETH) && (cfg.link_mode != LINK_HDLC);
    end

    o  = byte_offset_next;
    oc = {1'b0, o};

    if (!reject_flag_next) begin
      case (parse_phase_next)
        PH_LINK: begin
          if (cfg.link_mode == LINK_ETH) begin
            if (o == OFFSET_W'(12)) begin
              ether_kind_next = {b, 8'h00};
            end else if (o == OFFSET_W'(13)) begin
              ether_kind_next = ether_kind_next | {8'h00, b};
              if (ether_kind_next == ETYPE_VLAN) begin
                parse_phase_next = PH_VLAN;
              end else begin
                do_decide = 1'b1;
                base      = OFFSET_W'(14);
              end
            end
          end else begin
            if (o == OFFSET_W'(2)) begin
              ether_kind_next = {b, 8'h00};
            end else if (o == OFFSET_W'(3)) begin
              ether_kind_next = ether_kind_next | {8'h00, b};
              if (ether_kind_next == ETYPE_IPV4) begin
                ip_start_next    = OFFSET_W'(4);
                parse_phase_next = PH_IP;
              end else begin
                reject_flag_next = 1'b1;
              end
            end
          end
        end
        PH_VLAN: begin
          if (o == OFFSET_W'(16)) begin
            ether_kind_next = {b, 8'h00};
          end else if (o == OFFSET_W'(17)) begin
            ether_kind_next = ether_kind_next | {8'h00, b};
            do_decide       = 1'b1;
            base            = OFFSET_W'(18);
          end
        end
        PH_IP, PH_TCP_DONE: begin
          if (o >= ip_start_next) begin
            if (o == ip_start_next) begin
              tcp_start_next = ip_start_next + OFFSET_W'({b[3:0], 2'b00});
            end
            if (oc == {1'b0, ip_start_next} + CMP_W'(9)) begin
              ip_proto_next = b;
            end
            tc = {1'b0, tcp_start_next};
            if (oc == tc) begin
              src_port_next[15:8] = b;
            end
            if (oc == tc + CMP_W'(1)) begin
              src_port_next[7:0] = b;
            end
            if (oc == tc + CMP_W'(2)) begin
              dst_port_next[15:8] = b;
            end
            if (oc == tc + CMP_W'(3)) begin
              dst_port_next[7:0] = b;
            end
            if (parse_phase_next == PH_IP && oc == tc + CMP_W'(12)) begin
              payload_start_next = tcp_start_next + OFFSET_W'({b[7:4], 2'b00});
              parse_phase_next   = PH_TCP_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // ethertype after the link header or the VLAN tag
    if (do_decide) begin
      if (ether_kind_next == cfg.mpls_ethertype) begin
        ip_start_next    = base + MPLS_LABEL_BYTES;  // no IP check past the label
        parse_phase_next = PH_IP;
      end else if (ether_kind_next == ETYPE_IPV4) begin
        ip_start_next    = base;
        parse_phase_next = PH_IP;
      end else begin
        reject_flag_next = 1'b1;
      end
    end

    count    = oc + CMP_W'(1);
    color_ok = (held_color_next == 8'h00) || (held_color_next == cfg.tag_color);
    port_ok  = (src_port_next == cfg.port_first) || (src_port_next == cfg.port_second) ||
               (dst_port_next == cfg.port_first) || (dst_port_next == cfg.port_second);
    match    = !reject_flag_next && color_ok && (parse_phase_next == PH_TCP_DONE) &&
               (ip_proto_next == PROTO_TCP) && (count > {1'b0, payload_start_next}) &&
               port_ok;

    result.is_web    = match;
    result.color_out = match ? cfg.tag_color : held_color_next;

    if (item.last_byte) begin
      byte_offset_next   = '0;
      parse_phase_next   = PH_LINK;
      ether_kind_next    = '0;
      ip_start_next      = '0;
      tcp_start_next     = '0;
      payload_start_next = '0;
      ip_proto_next      = '0;
      src_port_next      = '0;
      dst_port_next      = '0;
      held_color_next    = '0;
      reject_flag_next   = 1'b0;
    end else begin
      byte_offset_next = (o < OFFSET_MAX) ? o + OFFSET_W'(1) : OFFSET_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      parse_phase   <= PH_LINK;
      ether_kind    <= '0;
      ip_start      <= '0;
      tcp_start     <= '0;
      payload_start <= '0;
      ip_proto      <= '0;
      src_port      <= '0;
      dst_port      <= '0;
      held_color    <= '0;
      reject_flag   <= 1'b0;
    end else if (step) begin
      byte_offset   <= byte_offset_next;
      parse_phase   <= parse_phase_next;
      ether_kind    <= ether_kind_next;
      ip_start      <= ip_start_next;
      tcp_start     <= tcp_start_next;
      payload_start <= payload_start_next;
      ip_proto      <= ip_proto_next;
      src_port      <= src_port_next;
      dst_port      <= dst_port_next;
      held_color    <= held_color_next;
      reject_flag   <= reject_flag_next;
    end
  end

endmodule

// ===== rtl/web_port_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// web_port_packet_classifier
// Classifies captured packets, one byte per request, as web traffic by TCP
// port and recolors matching packets.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      content
//  s_*       in   tvalid tready tdata tuser    tdata: pkt_byte, color_in
//                 tlast                        tuser: first_byte; tlast: last_byte
//  m_*       out  tvalid tready tdata tuser    tdata: color_out; tuser: is_web
//  cfg_*     in   we index data                register writes, no read-back
//
//  One byte per cycle sustained while no last byte waits for the result
//  register; a last byte goes through the input register, then the parse
//  logic into the result reg, and its result is valid from there.
//  rst (synchronous) empties both registers, clears the parse state and
//  loads register defaults.
//  While m_tready is low non-last bytes keep flowing; a last byte waits in
//  the input register until the result register is free.
// ----------------------------------------------------------------------------
module web_port_packet_classifier import wpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [7:0] pkt_byte, [15:8] color_in
  input  logic                  s_tuser,   // first_byte
  input  logic                  s_tlast,   // last_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] color_out
  output logic                  m_tuser,   // is_web
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   s_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_free;
  logic    step;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_mode      <= LINK_ETH;
      cfg.mpls_ethertype <= 16'h8847;
      cfg.tag_color      <= 8'd1;
      cfg.port_first     <= 16'd80;
      cfg.port_second    <= 16'd443;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINK_MODE:   cfg.link_mode      <= cfg_data[1:0];
        CFG_MPLS_ETYPE:  cfg.mpls_ethertype <= cfg_data;
        CFG_TAG_COLOR:   cfg.tag_color      <= cfg_data[7:0];
        CFG_PORT_FIRST:  cfg.port_first     <= cfg_data;
        CFG_PORT_SECOND: cfg.port_second    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_item.pkt_byte   = s_tdata[7:0];
  assign s_item.color_in   = s_tdata[15:8];
  assign s_item.first_byte = s_tuser;
  assign s_item.last_byte  = s_tlast;

  assign out_free = !m_tvalid || m_tready;
  assign step     = held_valid && (!held_item.last_byte || out_free);

  wpc_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_item    (s_item),
    .take      (step),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  wpc_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (held_item),
    .cfg   (cfg),
    .result(result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step && held_item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (step && held_item.last_byte) begin
      m_tdata <= result.color_out;
      m_tuser <= result.is_web;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the web port packet classifier. Packets go in one
// byte per request with random idling on both streams; an in-bench parser
// predicts each packet's verdict and checks it against the output stream.
// ----------------------------------------------------------------------------
module tb_top;
  import wpc_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [1:0]  LINK_NONE   = 2'd2;     // unsupported link types
  localparam logic [1:0]  LINK_NONE_HI = 2'd3;

  typedef enum logic [1:0] {
    PH_LINK     = 2'd0,
    PH_IP       = 2'd1,
    PH_TCP_DONE = 2'd2,
    PH_VLAN     = 2'd3
  } parse_phase_t;

  // Parses the byte stream like the block does and holds the verdicts still owed.
  class web_verdict_board;
    cfg_t         regs;
    int unsigned  pos;
    parse_phase_t phase;
    logic [15:0]  etype;
    int unsigned  ip_at, tcp_at, payload_at;
    logic [7:0]   proto;
    logic [15:0]  sport, dport;
    logic [7:0]   held_color;
    bit           dropped;
    result_t      pending[$];
    int           fails, verdicts, web_hits;

    function new();
      regs.link_mode      = LINK_ETH;
      regs.mpls_ethertype = 16'h8847;
      regs.tag_color      = 8'd1;
      regs.port_first     = 16'd80;
      regs.port_second    = 16'd443;
      fails = 0;
      verdicts = 0;
      web_hits = 0;
      restart();
    endfunction

    function void restart();
      pos = 0;
      phase = PH_LINK;
      etype = '0;
      ip_at = 0;
      tcp_at = 0;
      payload_at = 0;
      proto = '0;
      sport = '0;
      dport = '0;
      held_color = '0;
      dropped = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_LINK_MODE:   regs.link_mode      = val[1:0];
        CFG_MPLS_ETYPE:  regs.mpls_ethertype = val;
        CFG_TAG_COLOR:   regs.tag_color      = val[7:0];
        CFG_PORT_FIRST:  regs.port_first     = val;
        CFG_PORT_SECOND: regs.port_second    = val;
        default: ;
      endcase
    endfunction

    function void take_ethertype(logic [15:0] et, int unsigned base);
      if (et == regs.mpls_ethertype) begin
        ip_at = (base + MPLS_LABEL_BYTES) & OFFSET_MAX;
        phase = PH_IP;
      end else if (et == ETYPE_IPV4) begin
        ip_at = base & OFFSET_MAX;
        phase = PH_IP;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    function void parse(int unsigned o, logic [7:0] b);
      if (dropped) return;
      case (phase)
        PH_LINK: begin
          if (regs.link_mode == LINK_ETH) begin
            if (o == 12) begin
              etype = {b, 8'h00};
            end else if (o == 13) begin
              etype[7:0] = b;
              if (etype == ETYPE_VLAN) phase = PH_VLAN;
              else take_ethertype(etype, 14);
            end
          end else begin
            if (o == 2) begin
              etype = {b, 8'h00};
            end else if (o == 3) begin
              etype[7:0] = b;
              if (etype == ETYPE_IPV4) begin
                ip_at = 4;
                phase = PH_IP;
              end else begin
                dropped = 1'b1;
              end
            end
          end
        end
        PH_VLAN: begin
          if (o == 16) begin
            etype = {b, 8'h00};
          end else if (o == 17) begin
            etype[7:0] = b;
            take_ethertype(etype, 18);
          end
        end
        default: begin
          if (o >= ip_at) begin
            // header fields may overlap when IHL or data offset are tiny
            if (o == ip_at) tcp_at = (ip_at + int'(b[3:0]) * 4) & OFFSET_MAX;
            if (o == ip_at + 9) proto = b;
            if (o == tcp_at) sport[15:8] = b;
            if (o == tcp_at + 1) sport[7:0] = b;
            if (o == tcp_at + 2) dport[15:8] = b;
            if (o == tcp_at + 3) dport[7:0] = b;
            if (phase == PH_IP && o == tcp_at + 12) begin
              payload_at = (tcp_at + int'(b[7:4]) * 4) & OFFSET_MAX;
              phase = PH_TCP_DONE;
            end
          end
        end
      endcase
    endfunction

    function void take_byte(item_t it);
      int unsigned o;
      bit          hit;
      result_t     r;
      if (it.first_byte || pos == 0) begin
        restart();
        held_color = it.color_in;
        if (regs.link_mode >= LINK_NONE) dropped = 1'b1;
      end
      o = pos;
      parse(o, it.pkt_byte);
      if (it.last_byte) begin
        hit = !dropped && (held_color == 8'd0 || held_color == regs.tag_color) &&
              phase == PH_TCP_DONE && proto == PROTO_TCP && (o + 1 > payload_at) &&
              (sport == regs.port_first || sport == regs.port_second ||
               dport == regs.port_first || dport == regs.port_second);
        r.is_web    = hit;
        r.color_out = hit ? regs.tag_color : held_color;
        pending.push_back(r);
        restart();
      end else begin
        pos = (o < OFFSET_MAX) ? o + 1 : OFFSET_MAX;
      end
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= 10) $display("[%0t] MISMATCH verdict %0d: %s", $time, verdicts, what);
    endfunction

    function void check_verdict(logic is_web, logic [7:0] color);
      result_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result is_web=%0b color=%02h", is_web, color));
        return;
      end
      want = pending.pop_front();
      verdicts++;
      if (want.is_web) web_hits++;
      if (is_web !== want.is_web)
        flag($sformatf("is_web exp %0b got %0b", want.is_web, is_web));
      if (color !== want.color_out)
        flag($sformatf("color_out exp %02h got %02h", want.color_out, color));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;
  logic                  s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  web_verdict_board board = new();
  logic [7:0] frame_q[$];
  int  bytes_sent = 0;
  int  settings_used = 0;
  int  s_calm = 0;
  int  r_calm = 0;

  web_port_packet_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle cycles before the next request; occasional runs with no idling at all
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 60);
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [15:0] pick_port();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 30) return board.regs.port_first;
    if (p < 55) return board.regs.port_second;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_color();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 8'd0;
    if (p < 80) return board.regs.tag_color;
    return 8'($urandom);
  endfunction

  // Well-formed capture for the current link type, with random content.
  function automatic void build_frame();
    int unsigned ip_at, tcp_at, ihl, doff, body, len, pick;
    logic [15:0] et;
    logic [15:0] port;
    frame_q = {};
    if (board.regs.link_mode == LINK_HDLC) begin
      repeat (2) frame_q.push_back(8'($urandom));
      et = ($urandom_range(0, 4) != 0) ? ETYPE_IPV4 : 16'($urandom);
      frame_q.push_back(et[15:8]);
      frame_q.push_back(et[7:0]);
    end else begin
      repeat (12) frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        frame_q.push_back(ETYPE_VLAN[15:8]);
        frame_q.push_back(ETYPE_VLAN[7:0]);
        repeat (2) frame_q.push_back(8'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) et = ETYPE_IPV4;
      else if (pick < 85) et = board.regs.mpls_ethertype;
      else et = 16'($urandom);
      frame_q.push_back(et[15:8]);
      frame_q.push_back(et[7:0]);
      if (pick >= 60 && pick < 85) repeat (4) frame_q.push_back(8'($urandom));
    end
    ip_at  = frame_q.size();
    ihl    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : 5;
    doff   = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : 5;
    tcp_at = ip_at + ihl * 4;
    body   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
    len    = tcp_at + 13;
    if (tcp_at + doff * 4 > len) len = tcp_at + doff * 4;
    len += body;
    while (frame_q.size() < len) frame_q.push_back(8'($urandom));
    frame_q[ip_at]     = {(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h4), 4'(ihl)};
    frame_q[ip_at + 9] = ($urandom_range(0, 6) == 0) ? 8'($urandom) : PROTO_TCP;
    port = pick_port();
    frame_q[tcp_at]     = port[15:8];
    frame_q[tcp_at + 1] = port[7:0];
    port = pick_port();
    frame_q[tcp_at + 2] = port[15:8];
    frame_q[tcp_at + 3] = port[7:0];
    frame_q[tcp_at + 12] = {4'(doff), 4'($urandom)};
  endfunction

  task automatic send_item(logic [7:0] b, bit first, bit last, logic [7:0] color);
    int    gap;
    item_t it;
    gap = draw_wait(s_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.pkt_byte   = b;
    it.first_byte = first;
    it.last_byte  = last;
    it.color_in   = color;
    s_tvalid <= 1'b1;
    s_tdata  <= {color, b};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    board.take_byte(it);
    bytes_sent++;
  endtask

  task automatic send_frame(bit first, bit ends, logic [7:0] color);
    int i;
    for (i = 0; i < frame_q.size(); i++)
      send_item(frame_q[i], (i == 0) ? first : 1'b0, ends && (i == frame_q.size() - 1),
                (i == 0) ? color : 8'($urandom));
  endtask

  // stop feeding until every verdict is back, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic apply_setting(cfg_t c);
    write_reg(CFG_LINK_MODE, 16'(c.link_mode));
    write_reg(CFG_MPLS_ETYPE, c.mpls_ethertype);
    write_reg(CFG_TAG_COLOR, 16'(c.tag_color));
    write_reg(CFG_PORT_FIRST, c.port_first);
    write_reg(CFG_PORT_SECOND, c.port_second);
    settings_used++;
  endtask

  function automatic cfg_t phase_setting(int k);
    cfg_t c;
    c.link_mode      = LINK_ETH;
    c.mpls_ethertype = 16'h8847;
    c.tag_color      = 8'd1;
    c.port_first     = 16'd80;
    c.port_second    = 16'd443;
    case (k)
      0: ;
      1: begin
        c.link_mode      = LINK_HDLC;
        c.mpls_ethertype = 16'h0000;
        c.tag_color      = 8'd255;
        c.port_first     = 16'h0000;
        c.port_second    = 16'hFFFF;
      end
      2: begin
        c.mpls_ethertype = 16'hFFFF;
        c.tag_color      = 8'h5A;
        c.port_first     = 16'($urandom);
        c.port_second    = c.port_first;
      end
      3: begin
        c.mpls_ethertype = ETYPE_IPV4;   // label skip wins over plain IPv4
        c.tag_color      = 8'($urandom_range(1, 255));
        c.port_first     = 16'($urandom);
      end
      4: begin
        c.mpls_ethertype = ETYPE_VLAN;
        c.tag_color      = 8'd255;
        c.port_first     = 16'hFFFF;
        c.port_second    = 16'h0000;
      end
      5: c.link_mode = LINK_NONE;
      6: c.link_mode = LINK_NONE_HI;
      default: begin
        c.link_mode      = (k == 7) ? LINK_HDLC : LINK_ETH;
        c.mpls_ethertype = 16'($urandom);
        c.tag_color      = 8'($urandom_range(1, 255));
        c.port_first     = 16'($urandom);
        c.port_second    = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  task automatic run_traffic(int want_bytes, int want_ends);
    int          start_bytes, ends, kind, cut;
    bit          open;
    logic [7:0]  color;
    start_bytes = bytes_sent;
    ends = 0;
    open = 1'b0;
    while (bytes_sent - start_bytes < want_bytes || ends < want_ends || open) begin
      kind = $urandom_range(0, 99);
      build_frame();
      color = pick_color();
      if (kind >= 80 && kind < 90) begin
        frame_q = {};
        repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
      end else if (kind >= 90 && kind < 95) begin
        cut = $urandom_range(1, frame_q.size());
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      if (kind >= 95 && !open) begin
        // left open; the next start marker abandons it
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
        send_frame(1'b1, 1'b0, color);
        open = 1'b1;
      end else begin
        send_frame(open || ($urandom_range(0, 9) != 0), 1'b1, color);
        open = 1'b0;
        ends++;
        if ($urandom_range(0, 19) == 0) drain();
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(r_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      board.check_verdict(m_tuser, m_tdata);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_LINK_MODE;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // one-byte packets, start without marker, abandoned packet
    send_item(8'hFF, 1'b1, 1'b1, 8'hFF);
    send_item(8'h00, 1'b0, 1'b1, 8'h00);
    send_item(8'hAA, 1'b1, 1'b0, 8'h55);
    send_item(8'h12, 1'b1, 1'b1, 8'h00);
    drain();
    // HDLC with IHL 0 and data offset 0: IP and TCP headers fully overlap
    write_reg(CFG_LINK_MODE, 16'(LINK_HDLC));
    frame_q = {8'h0F, 8'h03, 8'h08, 8'h00, 8'h00, 8'h50, 8'h01, 8'hBB, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00};
    send_frame(1'b1, 1'b1, 8'h00);
    drain();

    for (k = 0; k < 10; k++) begin
      apply_setting(phase_setting(k));
      run_traffic(100, 2);
      drain();
    end
    repeat (10) @(posedge clk);

    $display("Run: %0d packet bytes, %0d verdicts (%0d web) over %0d register settings,",
             bytes_sent, board.verdicts, board.web_hits, settings_used);
    $display("  incl. Ethernet/VLAN/MPLS/HDLC framing, abandoned and truncated captures");
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wpc_pkg.sv
rtl/wpc_in_reg.sv
rtl/wpc_parser.sv
rtl/web_port_packet_classifier.sv
dv/tb_top.sv
